/* hw/rtl/priority_ready_queue_core_macros.svh */
`ifndef PRIORITY_READY_QUEUE_CORE_MACROS_SVH
`define PRIORITY_READY_QUEUE_CORE_MACROS_SVH

// same-cycle implication
`define PRQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/prq_pkg.sv */
package prq_pkg;

    localparam int TASK_SLOTS_DEF = 64;
    localparam int LEVELS_DEF     = 8;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic accept;
        logic commit;
    } prq_cmd_t;

endpackage

/* hw/rtl/prq_ctrl.sv */
`include "priority_ready_queue_core_macros.svh"

module prq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output prq_pkg::prq_cmd_t cmd
);
    import prq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_comb
    begin
        cmd.accept = (state_reg == ST_IDLE) && req_valid;
        cmd.commit = (state_reg == ST_FINISH) && (!rsp_valid_reg || !rsp_stall);
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (cmd.commit)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    `PRQ_ASSERT_NEXT(a_accept_then_finish, cmd.accept, state_reg == ST_FINISH,
        "accepted transaction did not move to finish")
    `PRQ_ASSERT_NEXT(a_commit_shows_result, cmd.commit, rsp_valid_reg,
        "commit did not present a result")
    `PRQ_ASSERT_NOW(a_no_commit_over_held, rsp_valid_reg && rsp_stall, !cmd.commit,
        "result overwritten while stalled")

endmodule

/* hw/rtl/prq_datapath.sv */
`include "priority_ready_queue_core_macros.svh"

module prq_datapath #(
    parameter int TASK_SLOTS = prq_pkg::TASK_SLOTS_DEF,
    parameter int LEVELS     = prq_pkg::LEVELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  prq_pkg::prq_cmd_t             cmd,
    input  logic                          operation,
    input  logic [$clog2(TASK_SLOTS)-1:0] task_id,
    input  logic [$clog2(LEVELS)-1:0]     priority_req,
    output logic                          found,
    output logic [$clog2(TASK_SLOTS)-1:0] popped_task,
    output logic [$clog2(LEVELS)-1:0]     popped_level
);
    import prq_pkg::*;

    localparam int ID_W  = $clog2(TASK_SLOTS);
    localparam int LVL_W = $clog2(LEVELS);
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);
    localparam logic [LVL_W:0]   LVL_LIM = (LVL_W + 1)'(LEVELS);
    localparam logic [ID_W:0]    ID_LIM  = (ID_W + 1)'(TASK_SLOTS);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TASK_SLOTS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // per-transaction registers
    logic             op_reg;
    logic [ID_W-1:0]  id_reg;
    logic [LVL_W-1:0] lvl_reg;
    logic             act_reg;

    // list state
    logic [ID_W-1:0]  link_mem [TASK_SLOTS];
    logic [ID_W-1:0]  rd_data_reg;
    logic [ID_W-1:0]  head_reg [LEVELS];
    logic [ID_W-1:0]  tail_reg [LEVELS];
    logic [CNT_W-1:0] cnt_reg  [LEVELS];
    logic [LEVELS-1:0] nonempty_reg;

    logic             found_reg;
    logic [ID_W-1:0]  popped_task_reg;
    logic [LVL_W-1:0] popped_level_reg;

    logic [LVL_W-1:0] top_lvl;
    logic             any_ne;
    logic [LVL_W-1:0] sel_lvl;
    logic [LVL_W-1:0] rd_idx;
    logic [CNT_W-1:0] sel_cnt;
    logic [CNT_W-1:0] cnt_dec;
    logic [ID_W-1:0]  sel_head;
    logic [ID_W-1:0]  sel_tail;
    logic             lvl_ok;
    logic             id_ok;
    logic             push_ok;
    logic             act_next;
    logic             mem_we;
    logic [ID_W-1:0]  mem_wa;
    logic [ID_W-1:0]  mem_wd;
    logic             mem_re;
    logic             push_commit;
    logic             pop_commit;

    always_comb
    begin
        top_lvl = '0;
        any_ne  = 1'b0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (nonempty_reg[i])
            begin
                top_lvl = LVL_W'(i);
                any_ne  = 1'b1;
            end
        end
    end

    always_comb
    begin
        lvl_ok  = ({1'b0, priority_req} < LVL_LIM);
        id_ok   = ({1'b0, task_id} < ID_LIM);
        sel_lvl = cmd.accept ? ((operation == OP_POP) ? top_lvl : priority_req) : lvl_reg;
        rd_idx  = ({1'b0, sel_lvl} < LVL_LIM) ? sel_lvl : '0;
        sel_cnt  = cnt_reg[rd_idx];
        sel_head = head_reg[rd_idx];
        sel_tail = tail_reg[rd_idx];
        cnt_dec  = sel_cnt - CNT_ONE;
        push_ok  = lvl_ok && id_ok && (sel_cnt < CNT_MAX);
        act_next = (operation == OP_POP) ? any_ne : push_ok;

        push_commit = cmd.commit && (op_reg == OP_PUSH) && act_reg;
        pop_commit  = cmd.commit && (op_reg == OP_POP) && act_reg;

        mem_we = (cmd.accept && (operation == OP_PUSH) && push_ok)
              || (push_commit && (sel_cnt != '0));
        mem_wa = cmd.accept ? task_id : sel_tail;
        mem_wd = cmd.accept ? '0 : id_reg;
        mem_re = cmd.accept && (operation == OP_POP) && any_ne;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= link_mem[sel_head];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= operation;
            id_reg  <= task_id;
            lvl_reg <= sel_lvl;
            act_reg <= act_next;
        end
        if (push_commit)
        begin
            if (sel_cnt == '0)
            begin
                head_reg[rd_idx] <= id_reg;
            end
            tail_reg[rd_idx] <= id_reg;
        end
        if (pop_commit)
        begin
            if (cnt_dec != '0)
            begin
                head_reg[rd_idx] <= rd_data_reg;
            end
            if (cnt_dec == CNT_ONE)
            begin
                tail_reg[rd_idx] <= rd_data_reg;
            end
        end
        if (cmd.commit)
        begin
            found_reg        <= pop_commit;
            popped_task_reg  <= pop_commit ? sel_head : '0;
            popped_level_reg <= pop_commit ? lvl_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            nonempty_reg <= '0;
        end
        else
        begin
            if (push_commit)
            begin
                cnt_reg[rd_idx]      <= sel_cnt + CNT_ONE;
                nonempty_reg[rd_idx] <= 1'b1;
            end
            else if (pop_commit)
            begin
                cnt_reg[rd_idx]      <= cnt_dec;
                nonempty_reg[rd_idx] <= (cnt_dec != '0);
            end
        end
    end

    assign found        = found_reg;
    assign popped_task  = popped_task_reg;
    assign popped_level = popped_level_reg;

    `PRQ_ASSERT_NOW(a_ne_matches_cnt, 1'b1, nonempty_reg[rd_idx] == (sel_cnt != '0),
        "nonempty flag disagrees with level count")
    `PRQ_ASSERT_NOW(a_pop_level_nonempty, pop_commit, nonempty_reg[lvl_reg],
        "pop committed on an empty level")
    `PRQ_ASSERT_NOW(a_cnt_bound, 1'b1, sel_cnt <= CNT_MAX,
        "level count exceeds task slots")

endmodule

/* hw/rtl/priority_ready_queue_core.sv */
// Multilevel priority ready queue: one FIFO of task ids per level, linked
// through a per-task link memory. Level LEVELS-1 is the highest priority.
// Request channel (req_valid/req_stall): operation selects push or pop;
// task_id and priority_req are used by a push and ignored by a pop.
// Response channel (rsp_valid/rsp_stall): exactly one response per request.
// A pop returns found=1 with the task and its level, or zeros when all
// levels are empty; a push returns found=0 with zeros.
// A request is accepted in the idle state, which reads the head's link from
// the link memory (or clears the new task's link); the finish state then
// updates the list and loads the response register, which drives rsp_valid.
// As the link memory read is registered, a new request is not accepted until
// the previous one has committed. A new request is taken while a response
// waits. If rsp_stall is held, the next request finishes its link memory
// access and then waits in the finish state until the held response is taken.
// Reset empties every level at once; the link memory is not cleared.
module priority_ready_queue_core #(
    parameter int TASK_SLOTS = prq_pkg::TASK_SLOTS_DEF,
    parameter int LEVELS     = prq_pkg::LEVELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          operation,
    input  logic [$clog2(TASK_SLOTS)-1:0] task_id,
    input  logic [$clog2(LEVELS)-1:0]     priority_req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic                          found,
    output logic [$clog2(TASK_SLOTS)-1:0] popped_task,
    output logic [$clog2(LEVELS)-1:0]     popped_level
);
    import prq_pkg::*;

    prq_cmd_t cmd;

    prq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    prq_datapath #(
        .TASK_SLOTS (TASK_SLOTS),
        .LEVELS     (LEVELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .operation    (operation),
        .task_id      (task_id),
        .priority_req (priority_req),
        .found        (found),
        .popped_task  (popped_task),
        .popped_level (popped_level)
    );

endmodule

/* test/priority_ready_queue_core_tb.sv */
module priority_ready_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prq_pkg::*;

    localparam int ID_W       = $clog2(TASK_SLOTS_DEF);
    localparam int LVL_W      = $clog2(LEVELS_DEF);
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic             found;
        logic [ID_W-1:0]  task_id;
        logic [LVL_W-1:0] level;
    } rsp_t;

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             req_valid    = 1'b0;
    logic             req_stall;
    logic             operation    = OP_PUSH;
    logic [ID_W-1:0]  task_id      = '0;
    logic [LVL_W-1:0] priority_req = '0;
    logic             rsp_valid;
    logic             rsp_stall    = 1'b0;
    logic             found;
    logic [ID_W-1:0]  popped_task;
    logic [LVL_W-1:0] popped_level;

    // shadow of the ready queue
    logic [ID_W-1:0]  next_task [TASK_SLOTS_DEF];
    logic [ID_W-1:0]  lvl_head  [LEVELS_DEF];
    logic [ID_W-1:0]  lvl_tail  [LEVELS_DEF];
    logic [ID_W:0]    lvl_count [LEVELS_DEF];
    bit               in_queue  [TASK_SLOTS_DEF];

    rsp_t due_rsp [$];
    rsp_t want;
    int   errors        = 0;
    int   src_idle_pct  = 0;
    int   snk_stall_pct = 0;
    int   quiet_cycles  = 0;

    priority_ready_queue_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .operation    (operation),
        .task_id      (task_id),
        .priority_req (priority_req),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .found        (found),
        .popped_task  (popped_task),
        .popped_level (popped_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < TASK_SLOTS_DEF; i++)
        begin
            next_task[i] = '0;
            in_queue[i]  = 1'b0;
        end
        for (int l = 0; l < LEVELS_DEF; l++)
        begin
            lvl_head[l]  = '0;
            lvl_tail[l]  = '0;
            lvl_count[l] = '0;
        end
    end

    task automatic ready_queue_step(input logic op, input logic [ID_W-1:0] id,
                                    input logic [LVL_W-1:0] lvl, output rsp_t r);
        int top;
        logic [ID_W-1:0] h;
        r   = '0;
        top = -1;
        if (op == OP_PUSH)
        begin
            if (lvl_count[lvl] < TASK_SLOTS_DEF)
            begin
                next_task[id] = '0;
                if (lvl_count[lvl] == 0)
                    lvl_head[lvl] = id;
                else
                    next_task[lvl_tail[lvl]] = id;
                lvl_tail[lvl]  = id;
                lvl_count[lvl] = lvl_count[lvl] + 1'b1;
            end
        end
        else
        begin
            for (int l = LEVELS_DEF - 1; l >= 0 && top < 0; l--)
                if (lvl_count[l] != 0)
                    top = l;
            if (top >= 0)
            begin
                h         = lvl_head[top];
                r.found   = 1'b1;
                r.task_id = h;
                r.level   = top[LVL_W-1:0];
                lvl_count[top] = lvl_count[top] - 1'b1;
                if (lvl_count[top] != 0)
                begin
                    lvl_head[top] = next_task[h];
                    if (lvl_count[top] == 1)
                        lvl_tail[top] = next_task[h];
                end
            end
        end
    endtask

    function automatic int queued_total();
        int n;
        n = 0;
        for (int l = 0; l < LEVELS_DEF; l++)
            n += lvl_count[l];
        return n;
    endfunction

    function automatic int pick_id(input bit queued);
        int start;
        int idx;
        start = $urandom_range(TASK_SLOTS_DEF - 1);
        for (int k = 0; k < TASK_SLOTS_DEF; k++)
        begin
            idx = (start + k) % TASK_SLOTS_DEF;
            if (in_queue[idx] == queued)
                return idx;
        end
        return -1;
    endfunction

    task automatic send_request(input logic op, input logic [ID_W-1:0] id,
                                input logic [LVL_W-1:0] lvl);
        rsp_t r;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid    <= 1'b1;
        operation    <= op;
        task_id      <= id;
        priority_req <= lvl;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        ready_queue_step(op, id, lvl, r);
        due_rsp.push_back(r);
        if (op == OP_PUSH)
            in_queue[id] = 1'b1;
        else if (r.found)
            in_queue[r.task_id] = 1'b0;
    endtask

    task automatic push_task(input logic [ID_W-1:0] id, input logic [LVL_W-1:0] lvl);
        send_request(OP_PUSH, id, lvl);
    endtask

    task automatic pop_task();
        send_request(OP_POP, ID_W'($urandom), LVL_W'($urandom));
    endtask

    task automatic hold_until_idle();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_rsp.size() != 0);
    endtask

    task automatic drain_levels();
        while (queued_total() != 0)
            pop_task();
        pop_task();
        hold_until_idle();
        for (int i = 0; i < TASK_SLOTS_DEF; i++)
            in_queue[i] = 1'b0;
    endtask

    task automatic test_basic_order();
        pop_task();
        push_task(6'd0, 3'd0);
        push_task(6'd63, 3'd7);
        push_task(6'd5, 3'd7);
        push_task(6'd42, 3'd3);
        push_task(6'd21, 3'd7);
        pop_task();
        pop_task();
        push_task(6'd9, 3'd7);
        pop_task();
        pop_task();
        push_task(6'd33, 3'd7);
        pop_task();
        pop_task();
        pop_task();
        pop_task();
        push_task(6'b101010, 3'b101);
        push_task(6'b010101, 3'b010);
        send_request(OP_POP, 6'd0, 3'd0);
        send_request(OP_POP, 6'd63, 3'd7);
        pop_task();
        hold_until_idle();
    endtask

    // the same task pushed until its level is full, then once more
    task automatic test_full_level();
        for (int i = 0; i <= TASK_SLOTS_DEF; i++)
            push_task(6'd17, 3'd4);
        push_task(6'd8, 3'd2);
        hold_until_idle();
        drain_levels();
    endtask

    task automatic test_random_traffic(input int n);
        int occ;
        int pop_pct;
        int roll;
        int id;
        for (int i = 0; i < n; i++)
        begin
            occ = queued_total();
            if (occ == 0)
                pop_pct = 8;
            else if ((i / 50) % 2 == 0)
                pop_pct = (occ > 48) ? 60 : 25;
            else
                pop_pct = 75;
            roll = $urandom_range(99);
            if (roll < pop_pct)
                pop_task();
            else if (roll >= 98 && occ != 0 && pick_id(1'b1) >= 0)
                push_task(ID_W'(pick_id(1'b1)), LVL_W'($urandom));
            else
            begin
                id = pick_id(1'b0);
                if (id < 0)
                    pop_task();
                else
                    push_task(ID_W'(id), LVL_W'($urandom));
            end
            if (i == n / 2)
                hold_until_idle();
        end
        drain_levels();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && !rsp_stall)
        begin
            if (due_rsp.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction found=%0b task=%0d level=%0d",
                         $time, found, popped_task, popped_level);
            end
            else
            begin
                want = due_rsp.pop_front();
                if (found !== want.found)
                begin
                    errors++;
                    $display("%0t: found expected %0b actual %0b", $time, want.found, found);
                end
                if (popped_task !== want.task_id)
                begin
                    errors++;
                    $display("%0t: popped_task expected %0d actual %0d",
                             $time, want.task_id, popped_task);
                end
                if (popped_level !== want.level)
                begin
                    errors++;
                    $display("%0t: popped_level expected %0d actual %0d",
                             $time, want.level, popped_level);
                end
            end
        end
        rsp_stall <= ($urandom_range(99) < snk_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        src_idle_pct  = 23;
        snk_stall_pct = 81;
        test_basic_order();
        test_full_level();
        test_random_traffic(250);
        src_idle_pct  = 81;
        snk_stall_pct = 23;
        test_random_traffic(250);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        test_random_traffic(250);
        repeat (10) @(posedge clk);
        if (errors == 0 && due_rsp.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
